FILE: rtl/dtic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtic_pkg - shared types and constants of the decimal text checker
// Phase codes, character codes, overflow limits and the records passed
// between the parser, the range judge and the top level.
// ----------------------------------------------------------------------------
package dtic_pkg;

   // Parse phase of the text being checked
   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,   // leading spaces or tabs
      PH_SIGN   = 3'd1,   // sign seen, digit required
      PH_DIGITS = 3'd2,   // inside the digits
      PH_TRAIL  = 3'd3,   // trailing whitespace
      PH_DONE   = 3'd4    // text ended or rejected
   } phase_type;

   // Character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Magnitude limits
   localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TENTH_LIMIT = 64'd922337203685477580;

   // Configuration register indexes
   localparam logic CSR_LOWER_BOUND = 1'b0;
   localparam logic CSR_UPPER_BOUND = 1'b1;

   // Final parse of one write, handed from parser to judge
   typedef struct packed {
      logic        bad;        // syntax error, overflow or no digit
      logic        negative;
      logic [63:0] magnitude;
   } parse_result_type;

   // Pipeline enables from the top level to the judge
   typedef struct packed {
      logic fin_en;     // final-parse stage may load
      logic fin_load;   // a write ends in this cycle
      logic out_en;     // result register may load
   } stage_ctrl_type;

   // Occupancy of the judge stages back to the top level
   typedef struct packed {
      logic fin_valid;
      logic out_valid;
   } stage_stat_type;

endpackage

FILE: rtl/dtic_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtic_parser - per-byte decimal text parser
// Holds the running parse state of the current write and advances it by one
// byte per request: phase, sign, magnitude (times ten plus digit), overflow
// and syntax flags, and the count of bytes examined.
// ----------------------------------------------------------------------------
module dtic_parser #(
   parameter int MAX_TEXT_BYTES = 63
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,          // consume the held request
   input  logic [7:0]                 char_code,
   input  logic                       byte_present,
   input  logic                       end_of_write,
   output dtic_pkg::parse_result_type result          // parse including this byte
);

   localparam int CW = $clog2(MAX_TEXT_BYTES + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TEXT_BYTES);

   dtic_pkg::phase_type phase_ff, phase_in;
   logic          neg_ff, neg_in;
   logic [63:0]   mag_ff, mag_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] seen_ff, seen_in;
   logic          bad_ff, bad_in;

   logic        examine;
   logic        is_digit, is_blank, is_trail, is_sign, is_nul;
   logic [3:0]  digit_val;
   logic [63:0] limit, mag_x10;
   logic        add_ovf;

   // Classify the byte
   assign is_digit  = (char_code >= dtic_pkg::CHAR_ZERO) && (char_code <= dtic_pkg::CHAR_NINE);
   assign is_blank  = (char_code == dtic_pkg::CHAR_SPACE) || (char_code == dtic_pkg::CHAR_TAB);
   assign is_trail  = is_blank || (char_code == dtic_pkg::CHAR_LF)
                      || (char_code == dtic_pkg::CHAR_CR);
   assign is_sign   = (char_code == dtic_pkg::CHAR_PLUS) || (char_code == dtic_pkg::CHAR_MINUS);
   assign is_nul    = (char_code == dtic_pkg::CHAR_NUL);
   assign examine   = byte_present && (seen_ff < COUNT_MAX);
   assign digit_val = 4'(char_code - dtic_pkg::CHAR_ZERO);

   // Multiply by ten and add the digit, check against the signed limit
   assign limit   = neg_ff ? dtic_pkg::SIGN_BIT : (dtic_pkg::SIGN_BIT - 64'd1);
   assign mag_x10 = (mag_ff << 3) + (mag_ff << 1) + {60'd0, digit_val};
   assign add_ovf = (mag_ff > dtic_pkg::TENTH_LIMIT) || (mag_x10 > limit);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (examine && (phase_ff != dtic_pkg::PH_DONE)) begin
         if (is_nul) begin
            phase_in = dtic_pkg::PH_DONE;
         end else begin
            unique case (phase_ff)
               dtic_pkg::PH_LEAD: begin
                  if (is_blank)      phase_in = dtic_pkg::PH_LEAD;
                  else if (is_sign)  phase_in = dtic_pkg::PH_SIGN;
                  else if (is_digit) phase_in = dtic_pkg::PH_DIGITS;
                  else               phase_in = dtic_pkg::PH_DONE;
               end
               dtic_pkg::PH_SIGN: begin
                  phase_in = is_digit ? dtic_pkg::PH_DIGITS : dtic_pkg::PH_DONE;
               end
               dtic_pkg::PH_DIGITS: begin
                  if (is_digit)      phase_in = dtic_pkg::PH_DIGITS;
                  else if (is_trail) phase_in = dtic_pkg::PH_TRAIL;
                  else               phase_in = dtic_pkg::PH_DONE;
               end
               default: begin
                  phase_in = is_trail ? phase_ff : dtic_pkg::PH_DONE;
               end
            endcase
         end
      end
   end

   // Datapath updates: sign, magnitude, flags, byte count
   always_comb begin
      logic take_digit;
      logic reject;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      ovf_in     = ovf_ff;
      bad_in     = bad_ff;
      seen_in    = seen_ff;
      take_digit = 1'b0;
      reject     = 1'b0;
      if (examine) begin
         seen_in = seen_ff + CW'(1);
         if (phase_ff != dtic_pkg::PH_DONE) begin
            if (is_nul) begin
               reject = (phase_ff == dtic_pkg::PH_LEAD) || (phase_ff == dtic_pkg::PH_SIGN);
            end else begin
               unique case (phase_ff)
                  dtic_pkg::PH_LEAD: begin
                     take_digit = is_digit;
                     reject     = !is_blank && !is_sign && !is_digit;
                     if (is_sign) neg_in = (char_code == dtic_pkg::CHAR_MINUS);
                  end
                  dtic_pkg::PH_SIGN: begin
                     take_digit = is_digit;
                     reject     = !is_digit;
                  end
                  dtic_pkg::PH_DIGITS: begin
                     take_digit = is_digit;
                     reject     = !is_digit && !is_trail;
                  end
                  default: begin
                     reject = !is_trail;
                  end
               endcase
            end
         end
      end
      if (reject) bad_in = 1'b1;
      // Accumulate the digit unless already overflowed
      if (take_digit && !ovf_ff) begin
         if (add_ovf) ovf_in = 1'b1;
         else         mag_in = mag_x10;
      end
   end

   // Parse as it stands after this byte
   assign result.bad = bad_in || ovf_in || (phase_in == dtic_pkg::PH_LEAD)
                       || (phase_in == dtic_pkg::PH_SIGN);
   assign result.negative  = neg_in;
   assign result.magnitude = mag_in;

   // Hold state; clear it when a write ends
   always_ff @(posedge clock) begin
      if (reset || (take && end_of_write)) begin
         phase_ff <= dtic_pkg::PH_LEAD;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
         ovf_ff   <= 1'b0;
         seen_ff  <= '0;
         bad_ff   <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

FILE: rtl/dtic_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtic_judge - range check and result register
// Latches the final parse of a write, forms the signed value, checks it
// against the configured bounds (non-negative only when both are 0) and holds the result until it is taken.
// ----------------------------------------------------------------------------
module dtic_judge (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wen,
   input  logic                       csr_index,
   input  logic [63:0]                csr_wdata,
   input  dtic_pkg::stage_ctrl_type   ctrl,
   input  dtic_pkg::parse_result_type parse,
   output dtic_pkg::stage_stat_type   stat,
   output logic                       status,
   output logic [63:0]                parsed_value
);

   logic [63:0] lower_ff, upper_ff;
   logic        fin_valid_ff;
   dtic_pkg::parse_result_type fin_ff;
   logic        out_valid_ff;
   logic        status_ff, status_in;
   logic [63:0] value_ff, value_in, signed_val;
   logic        in_range;

   // Bounds registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
      end else if (csr_wen) begin
         if (csr_index == dtic_pkg::CSR_LOWER_BOUND) lower_ff <= csr_wdata;
         else                                        upper_ff <= csr_wdata;
      end
   end

   // Final-parse stage
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (ctrl.fin_en) begin
         fin_valid_ff <= ctrl.fin_load;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.fin_en && ctrl.fin_load) begin
         fin_ff <= parse;
      end
   end

   // Signed value and bounds check
   assign signed_val = fin_ff.negative ? (64'd0 - fin_ff.magnitude) : fin_ff.magnitude;

   always_comb begin
      if ((lower_ff == 64'd0) && (upper_ff == 64'd0)) begin
         in_range = !signed_val[63];
      end else begin
         in_range = ($signed(signed_val) >= $signed(lower_ff))
                    && ($signed(signed_val) <= $signed(upper_ff));
      end
      status_in = fin_ff.bad || !in_range;
      value_in  = status_in ? 64'd0 : signed_val;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctrl.out_en) begin
         out_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_en && fin_valid_ff) begin
         status_ff <= status_in;
         value_ff  <= value_in;
      end
   end

   assign stat.fin_valid = fin_valid_ff;
   assign stat.out_valid = out_valid_ff;
   assign status         = status_ff;
   assign parsed_value   = value_ff;

endmodule

FILE: rtl/decimal_text_to_integer_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_integer_checker_core - signed decimal text checker
// Parses the bytes of one text write as a signed 64-bit decimal number and
// reports, on the write's last request, whether it is valid and in range.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while req_tready is high, each
// carrying at most one byte of text, and keeps a running parse of the write.
// On the request with req_tlast set it presents one result, which passes from
// the request register through the final-parse register to the result
// register. rsp_tuser is 0 when the text is a well-formed number that fits
// 64-bit signed and lies in the configured range (any non-negative value when
// both bounds are 0), and rsp_tdata then holds the value; otherwise
// rsp_tuser is 1 and rsp_tdata is 0. The sustained rate is one request per
// cycle, set by the per-byte multiply-by-ten-and-add of the magnitude, while
// requests are not stalled. A stalled result reaches the input only when a
// request that ends a write finds the final-parse and result registers both
// full; that request then waits in the request register. Write the bounds
// only while no write is in progress and no result is pending.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_checker_core #(
   parameter int MAX_TEXT_BYTES = 63
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_code
   input  logic        req_tuser,    // [0] byte_present
   input  logic        req_tlast,    // end_of_write
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [63:0] parsed_value
   output logic        rsp_tuser,    // [0] status
   // configuration port
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   logic        in_valid_ff;
   logic [7:0]  in_char_ff;
   logic        in_present_ff;
   logic        in_end_ff;
   logic        consume;
   logic        in_en;

   dtic_pkg::stage_ctrl_type   ctrl;
   dtic_pkg::stage_stat_type   stat;
   dtic_pkg::parse_result_type parse;

   // Stage enables: each stage loads when empty or when drained downstream
   assign ctrl.out_en   = !stat.out_valid || rsp_tready;
   assign ctrl.fin_en   = !stat.fin_valid || ctrl.out_en;
   assign consume       = in_valid_ff && (!in_end_ff || ctrl.fin_en);
   assign ctrl.fin_load = consume && in_end_ff;
   assign in_en         = !in_valid_ff || consume;
   assign req_tready    = in_en;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en && req_tvalid) begin
         in_char_ff    <= req_tdata;
         in_present_ff <= req_tuser;
         in_end_ff     <= req_tlast;
      end
   end

   dtic_parser #(
      .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .take         (consume),
      .char_code    (in_char_ff),
      .byte_present (in_present_ff),
      .end_of_write (in_end_ff),
      .result       (parse)
   );

   dtic_judge u_judge (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .ctrl         (ctrl),
      .parse        (parse),
      .stat         (stat),
      .status       (rsp_tuser),
      .parsed_value (rsp_tdata)
   );

   assign rsp_tvalid = stat.out_valid;

endmodule

FILE: tb/decimal_text_to_integer_checker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_integer_checker_core_tb - self-checking bench of the checker
// Streams text writes one byte per request and predicts, for every request
// that ends a write, the status and value that the core should return.
// Directed corner cases come first, then random writes over several bound
// settings. Sender and receiver idle at random, and a long receiver hold-off
// backs the core up. Results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_checker_core_tb;

   localparam int TEXT_LIMIT   = 63;
   localparam int LONG_STALL   = 400;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_COUNT  = 7;
   localparam int PHASE_ITEMS  = 230;

   localparam logic signed [63:0] VALUE_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic [7:0] TRAIL_CHARS [4] = '{dtic_pkg::CHAR_SPACE, dtic_pkg::CHAR_TAB,
                                              dtic_pkg::CHAR_LF, dtic_pkg::CHAR_CR};

   typedef struct packed {
      logic [7:0] code;
      logic       present;
      logic       last;
   } text_request_type;

   typedef struct packed {
      logic        status;
      logic [63:0] value;
   } parse_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wen = 1'b0;
   logic        csr_index = dtic_pkg::CSR_LOWER_BOUND;
   logic [63:0] csr_wdata = 64'd0;

   text_request_type  pending_requests [$];
   parse_outcome_type expected_results [$];
   logic [7:0]        text_buf [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stalls_asked = 0;
   int stalls_granted = 0;
   int stall_left = 0;
   int items_queued = 0;
   int failures = 0;
   int cycle_count = 0;
   logic req_taken = 1'b0;

   // Predictor copy of the bounds and of the running parse
   logic signed [63:0]  bound_lo = 64'sd0;
   logic signed [63:0]  bound_hi = 64'sd0;
   dtic_pkg::phase_type text_phase = dtic_pkg::PH_LEAD;
   logic                text_negative = 1'b0;
   logic [63:0]         text_magnitude = 64'd0;
   logic                text_overflow = 1'b0;
   int                  text_count = 0;
   logic                text_malformed = 1'b0;

   decimal_text_to_integer_checker_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic void clear_parse();
      text_phase     = dtic_pkg::PH_LEAD;
      text_negative  = 1'b0;
      text_magnitude = 64'd0;
      text_overflow  = 1'b0;
      text_count     = 0;
      text_malformed = 1'b0;
   endfunction

   function automatic void accumulate_digit(logic [7:0] d);
      logic [63:0] limit;
      logic [63:0] next;
      limit = text_negative ? dtic_pkg::SIGN_BIT : dtic_pkg::SIGN_BIT - 64'd1;
      if (text_overflow) return;
      if (text_magnitude > dtic_pkg::TENTH_LIMIT) begin
         text_overflow = 1'b1;
         return;
      end
      next = text_magnitude * 64'd10 + 64'(d);
      if (next > limit) text_overflow = 1'b1;
      else text_magnitude = next;
   endfunction

   function automatic void absorb_char(logic [7:0] c);
      logic is_digit;
      logic is_blank;
      logic is_trail;
      is_digit = (c >= dtic_pkg::CHAR_ZERO) && (c <= dtic_pkg::CHAR_NINE);
      is_blank = (c == dtic_pkg::CHAR_SPACE) || (c == dtic_pkg::CHAR_TAB);
      is_trail = is_blank || (c == dtic_pkg::CHAR_LF) || (c == dtic_pkg::CHAR_CR);
      // Bytes beyond the window are dropped
      if (text_count >= TEXT_LIMIT) return;
      text_count++;
      if (text_phase == dtic_pkg::PH_DONE) return;
      // A zero byte ends the text
      if (c == dtic_pkg::CHAR_NUL) begin
         if (text_phase == dtic_pkg::PH_LEAD || text_phase == dtic_pkg::PH_SIGN)
            text_malformed = 1'b1;
         text_phase = dtic_pkg::PH_DONE;
         return;
      end
      case (text_phase)
         dtic_pkg::PH_LEAD: begin
            if (is_blank) begin
            end else if (c == dtic_pkg::CHAR_MINUS || c == dtic_pkg::CHAR_PLUS) begin
               text_negative = (c == dtic_pkg::CHAR_MINUS);
               text_phase = dtic_pkg::PH_SIGN;
            end else if (is_digit) begin
               accumulate_digit(c - dtic_pkg::CHAR_ZERO);
               text_phase = dtic_pkg::PH_DIGITS;
            end else begin
               text_malformed = 1'b1;
               text_phase = dtic_pkg::PH_DONE;
            end
         end
         dtic_pkg::PH_SIGN: begin
            if (is_digit) begin
               accumulate_digit(c - dtic_pkg::CHAR_ZERO);
               text_phase = dtic_pkg::PH_DIGITS;
            end else begin
               text_malformed = 1'b1;
               text_phase = dtic_pkg::PH_DONE;
            end
         end
         dtic_pkg::PH_DIGITS: begin
            if (is_digit) begin
               accumulate_digit(c - dtic_pkg::CHAR_ZERO);
            end else if (is_trail) begin
               text_phase = dtic_pkg::PH_TRAIL;
            end else begin
               text_malformed = 1'b1;
               text_phase = dtic_pkg::PH_DONE;
            end
         end
         default: begin
            if (!is_trail) begin
               text_malformed = 1'b1;
               text_phase = dtic_pkg::PH_DONE;
            end
         end
      endcase
   endfunction

   // Judge the finished text against the bounds, then start a fresh write
   function automatic parse_outcome_type judge_write();
      parse_outcome_type  outcome;
      logic               rejected;
      logic signed [63:0] val;
      rejected = text_malformed || text_overflow ||
                 text_phase == dtic_pkg::PH_LEAD || text_phase == dtic_pkg::PH_SIGN;
      val = text_negative ? 64'd0 - text_magnitude : text_magnitude;
      if (!rejected) begin
         if (bound_lo == 64'sd0 && bound_hi == 64'sd0) rejected = val[63];
         else rejected = (val < bound_lo) || (val > bound_hi);
      end
      outcome.status = rejected;
      outcome.value  = rejected ? 64'd0 : val;
      clear_parse();
      return outcome;
   endfunction

   // ---------------------------------------------------------------- stimulus
   task automatic add_chr(logic [7:0] c);
      text_buf.push_back(c);
   endtask

   task automatic add_str(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // Turn the text buffer into requests; end on the last byte or on an empty item
   task automatic queue_write(bit end_on_byte, int gap_pct);
      text_request_type item;
      for (int i = 0; i < text_buf.size(); i++) begin
         if ($urandom_range(0, 99) < gap_pct) begin
            item = '{code: 8'($urandom), present: 1'b0, last: 1'b0};
            pending_requests.push_back(item);
         end
         item = '{code: text_buf[i], present: 1'b1,
                  last: end_on_byte && (i == text_buf.size() - 1)};
         pending_requests.push_back(item);
         items_queued++;
      end
      if (!end_on_byte || text_buf.size() == 0) begin
         item = '{code: 8'($urandom), present: 1'b0, last: 1'b1};
         pending_requests.push_back(item);
         items_queued++;
      end
      text_buf.delete();
   endtask

   function automatic logic signed [63:0] pick_value();
      int k;
      k = $urandom_range(0, 4) - 2;
      case ($urandom_range(0, 3))
         0: return $signed($urandom_range(0, 2000)) - 1000;
         1: return {$urandom, $urandom};
         2: return $urandom_range(0, 1) ? VALUE_MAX - $urandom_range(0, 3)
                                        : VALUE_MIN + $urandom_range(0, 3);
         default: return ($urandom_range(0, 1) ? bound_lo : bound_hi) + k;
      endcase
   endfunction

   task automatic queue_random_write();
      int          kind;
      string       digits;
      logic signed [63:0] v;
      logic [7:0]  sign_chr;
      kind = $urandom_range(0, 99);
      sign_chr = $urandom_range(0, 1) ? dtic_pkg::CHAR_MINUS : dtic_pkg::CHAR_PLUS;
      if (kind < 75) begin
         // Well-formed shape with random content
         if ($urandom_range(0, 39) == 0)
            repeat ($urandom_range(55, 70)) add_chr(dtic_pkg::CHAR_SPACE);
         else
            repeat ($urandom_range(0, 2))
               add_chr($urandom_range(0, 1) ? dtic_pkg::CHAR_SPACE : dtic_pkg::CHAR_TAB);
         v = pick_value();
         digits = $sformatf("%0d", v);
         if (digits[0] == dtic_pkg::CHAR_MINUS) begin
            add_chr(dtic_pkg::CHAR_MINUS);
            digits = digits.substr(1, digits.len() - 1);
         end else if ($urandom_range(0, 3) == 0) begin
            add_chr(dtic_pkg::CHAR_PLUS);
         end
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) add_chr(dtic_pkg::CHAR_ZERO);
         add_str(digits);
         // An extra digit often pushes the value out of range
         if ($urandom_range(0, 9) == 0) add_chr(8'(dtic_pkg::CHAR_ZERO + $urandom_range(0, 9)));
         repeat ($urandom_range(0, 2)) add_chr(TRAIL_CHARS[$urandom_range(0, 3)]);
         if ($urandom_range(0, 9) == 0) begin
            add_chr(dtic_pkg::CHAR_NUL);
            repeat ($urandom_range(0, 3)) add_chr(8'($urandom));
         end
      end else if (kind < 90) begin
         // Broken sequences
         digits = $sformatf("%0d", $urandom_range(0, 99999));
         case ($urandom_range(0, 5))
            0: add_chr(sign_chr);
            1: repeat ($urandom_range(0, 3))
                  add_chr($urandom_range(0, 1) ? dtic_pkg::CHAR_SPACE : dtic_pkg::CHAR_TAB);
            2: begin
               add_str(digits);
               add_chr(8'($urandom_range(8'h3A, 8'h7E)));
            end
            3: begin
               add_chr(8'($urandom_range(8'h3A, 8'h7E)));
               add_str(digits);
            end
            4: begin
               add_chr(sign_chr);
               add_chr(dtic_pkg::CHAR_SPACE);
               add_str(digits);
            end
            default: begin
               add_str(digits);
               add_chr(TRAIL_CHARS[$urandom_range(0, 3)]);
               add_str(digits);
            end
         endcase
      end else begin
         // Noise bytes
         repeat ($urandom_range(0, 6)) add_chr(8'($urandom));
      end
      queue_write($urandom_range(0, 1), 4);
   endtask

   // Write both bounds on consecutive cycles while the core is idle
   task automatic set_bounds(logic signed [63:0] lo, logic signed [63:0] hi);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= dtic_pkg::CSR_LOWER_BOUND;
      csr_wdata <= lo;
      bound_lo = lo;
      @(negedge clock);
      csr_index <= dtic_pkg::CSR_UPPER_BOUND;
      csr_wdata <= hi;
      bound_hi = hi;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // Wait until every request is taken and every result has come back
   task automatic wait_quiet();
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      logic signed [63:0] lo_tab [PHASE_COUNT];
      logic signed [63:0] hi_tab [PHASE_COUNT];
      logic signed [63:0] a;
      logic signed [63:0] b;
      int start;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      lo_tab = '{64'sd0, VALUE_MIN, -64'sd1000, VALUE_MAX, 64'sd100, 64'sd0, VALUE_MIN};
      hi_tab = '{64'sd0, VALUE_MAX, 64'sd1000, VALUE_MAX, -64'sd100, 64'sd0, -64'sd1};
      lo_tab[5] = (a < b) ? a : b;
      hi_tab[5] = (a < b) ? b : a;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         send_idle_pct = (p < 2) ? 17 : (p < 4) ? 52 : 0;
         recv_idle_pct = (p < 2) ? 52 : (p < 4) ? 17 : 0;
         set_bounds(lo_tab[p], hi_tab[p]);
         start = items_queued;
         if (p == 0) begin
            // Directed corner cases under the non-negative rule
            add_str("0"); queue_write(1, 0);
            add_str("9223372036854775807"); queue_write(0, 0);
            add_str("9223372036854775808"); queue_write(1, 0);
            add_str("-1"); queue_write(1, 0);
            add_str("-9223372036854775808"); queue_write(0, 0);
            add_str("-9223372036854775809"); queue_write(1, 0);
            add_chr(dtic_pkg::CHAR_SPACE); add_chr(dtic_pkg::CHAR_TAB); add_str("+42");
            add_chr(dtic_pkg::CHAR_SPACE); add_chr(dtic_pkg::CHAR_LF);
            add_chr(dtic_pkg::CHAR_CR); queue_write(1, 0);
            queue_write(0, 0);
            add_str("  "); add_chr(dtic_pkg::CHAR_TAB); queue_write(1, 0);
            add_str("-"); queue_write(0, 0);
            add_str("+"); queue_write(1, 0);
            add_str("12a"); queue_write(1, 0);
            add_str("1 2"); queue_write(0, 0);
            add_chr(dtic_pkg::CHAR_NUL); queue_write(1, 0);
            add_str("5"); add_chr(dtic_pkg::CHAR_NUL); add_str("x7"); queue_write(1, 0);
            add_str("-"); add_chr(dtic_pkg::CHAR_NUL); queue_write(0, 0);
            add_str("1"); repeat (62) add_chr(dtic_pkg::CHAR_SPACE); add_str("x");
            queue_write(1, 0);
            repeat (63) add_chr(dtic_pkg::CHAR_SPACE); add_str("5"); queue_write(0, 0);
            add_str("99999999999999999999999"); queue_write(1, 0);
            add_str("37"); queue_write(1, 60);
            add_chr(8'hFF); queue_write(1, 0);
            add_str("00000000000000000000042"); queue_write(0, 0);
         end
         while (items_queued - start < PHASE_ITEMS) queue_random_write();
         if (p == 4 || p == 5) stalls_asked++;
         wait_quiet();
      end

      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver
   // Offer the next request once the current one is taken, with random gaps
   always @(negedge clock) begin
      text_request_type item;
      if (!req_tvalid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            item = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.code;
            req_tuser  <= item.present;
            req_tlast  <= item.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   // Hold off for a long stretch when asked, else stall at random
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_granted < stalls_asked) begin
         rsp_tready     <= 1'b0;
         stall_left     <= LONG_STALL;
         stalls_granted <= stalls_granted + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      parse_outcome_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
         clear_parse();
      end else begin
         req_taken <= req_tvalid && req_tready;
         // Predict on every accepted request
         if (req_tvalid && req_tready) begin
            if (req_tuser) absorb_char(req_tdata);
            if (req_tlast) expected_results.push_back(judge_write());
         end
         // Compare every accepted result with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result with no request outstanding: status %0d value %0d",
                      rsp_tuser, $signed(rsp_tdata));
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  failures++;
               end
               if (rsp_tdata !== want.value) begin
                  $error("parsed_value: expected %0d, got %0d",
                         $signed(want.value), $signed(rsp_tdata));
                  failures++;
               end
            end
         end
      end
   end

endmodule
